>>> rtl/sesv_pkg.sv
// ----------------------------------------------------------------------------
// sesv_pkg
// Types, widths and codes shared by the stratified SGS eddy viscosity core.
// ----------------------------------------------------------------------------
package sesv_pkg;

	localparam int VOL_W   = 48;
	localparam int UQ_W    = 31;
	localparam int SQ_W    = 32;
	localparam int DOT_W   = 64;
	localparam int NUM1_W  = 95;
	localparam int STRAT_W = 79;
	localparam int QLIM_W  = 40;
	localparam int LEN_W   = 20;
	localparam int ROOT_W  = 24;
	localparam int CBRT_IW = 56;
	localparam int CBRT_RW = 19;
	localparam int CBRT_DW = 60;
	localparam int CBRT_R3 = 21;
	localparam int CBRT_S3 = 40;
	localparam int TDATA_IN_W  = 240;
	localparam int TDATA_OUT_W = 64;

	localparam logic [1:0] DIMS_2D = 2'd2;

	typedef enum logic [2:0] {
		CFG_EXPANSION = 3'd0,
		CFG_GRAVITY_X = 3'd1,
		CFG_GRAVITY_Y = 3'd2,
		CFG_GRAVITY_Z = 3'd3,
		CFG_VISCOSITY = 3'd4,
		CFG_DIMS      = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic        [UQ_W-1:0] expansion_coeff;
		logic signed [SQ_W-1:0] gravity_x;
		logic signed [SQ_W-1:0] gravity_y;
		logic signed [SQ_W-1:0] gravity_z;
		logic        [UQ_W-1:0] viscosity_coeff;
		logic        [1:0]      space_dims;
	} cfg_regs_t;

	localparam logic signed [SQ_W-1:0] GRAVITY_Z_RST = -32'sd642908;
	localparam logic [UQ_W-1:0]        VISC_RST      = 31'd5610;

	typedef struct packed {
		logic [2:0]             pad;
		logic        [UQ_W-1:0] heat_capacity;
		logic signed [SQ_W-1:0] grad_z;
		logic signed [SQ_W-1:0] grad_y;
		logic signed [SQ_W-1:0] grad_x;
		logic        [UQ_W-1:0] fluid_density;
		logic        [UQ_W-1:0] kinetic_energy;
		logic       [VOL_W-1:0] cell_volume;
	} in_item_t;

	typedef struct packed {
		logic [1:0]      pad;
		logic [UQ_W-1:0] eddy_viscosity;
		logic [UQ_W-1:0] length_scale;
	} out_item_t;

	typedef struct packed {
		logic [VOL_W-1:0] vol;
		logic [UQ_W-1:0]  ke;
		logic [UQ_W-1:0]  rho;
		logic [UQ_W-1:0]  cp;
	} dot_side_t;

	typedef struct packed {
		logic [VOL_W-1:0] vol;
		logic [UQ_W-1:0]  ke;
		logic [UQ_W-1:0]  rho;
	} div_side_t;

	typedef struct packed {
		logic [VOL_W-1:0] vol;
		logic [UQ_W-1:0]  ke;
		logic [UQ_W-1:0]  rho;
		logic             ovf;
	} lim_side_t;

	typedef struct packed {
		logic [VOL_W-1:0] vol;
		logic [UQ_W-1:0]  ke;
		logic [UQ_W-1:0]  rho;
		logic             ovf;
		logic [LEN_W-1:0] limit;
	} f2_side_t;

	typedef struct packed {
		logic [UQ_W-1:0]  ke;
		logic [UQ_W-1:0]  rho;
		logic             ovf;
		logic [LEN_W-1:0] limit;
		logic [LEN_W-1:0] f2d;
	} f3_side_t;

	typedef struct packed {
		logic [UQ_W-1:0]  rho;
		logic [LEN_W-1:0] length;
	} rt_side_t;

endpackage

>>> rtl/sesv_dot.sv
// ----------------------------------------------------------------------------
// sesv_dot
// Gravity dot gradient, clamped to positive, times expansion coefficient.
// ----------------------------------------------------------------------------
module sesv_dot #(
	parameter int SW = 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic signed [sesv_pkg::SQ_W-1:0]      grad_x,
	input  logic signed [sesv_pkg::SQ_W-1:0]      grad_y,
	input  logic signed [sesv_pkg::SQ_W-1:0]      grad_z,
	input  logic signed [sesv_pkg::SQ_W-1:0]      gravity_x,
	input  logic signed [sesv_pkg::SQ_W-1:0]      gravity_y,
	input  logic signed [sesv_pkg::SQ_W-1:0]      gravity_z,
	input  logic                                  two_d,
	input  logic        [sesv_pkg::UQ_W-1:0]      beta,
	input  logic        [SW-1:0]                  in_side,
	output logic                                  out_vld,
	output logic        [sesv_pkg::NUM1_W-1:0]    num,
	output logic        [SW-1:0]                  out_side
);

	localparam int PW = 2 * sesv_pkg::SQ_W;
	localparam int HW = sesv_pkg::DOT_W / 2;
	localparam int BW = sesv_pkg::UQ_W + HW;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic [sesv_pkg::DOT_W-1:0] pos_s2;
	logic [BW-1:0]       plo_s3, phi_s3;
	logic [sesv_pkg::NUM1_W-1:0] num_s4;
	logic [SW-1:0]       side_s1, side_s2, side_s3, side_s4;
	logic signed [PW+1:0] dot;
	logic signed [sesv_pkg::SQ_W-1:0] gz;

	// z term drops out in two dimensions
	assign gz  = two_d ? '0 : gravity_z;
	assign dot = (PW+2)'(px_s1) + (PW+2)'(py_s1) + (PW+2)'(pz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= gravity_x * grad_x;
			py_s1   <= gravity_y * grad_y;
			pz_s1   <= gz * grad_z;
			side_s1 <= in_side;
			pos_s2  <= (!dot[PW+1] && dot != '0) ? dot[sesv_pkg::DOT_W-1:0] : '0;
			side_s2 <= side_s1;
			plo_s3  <= BW'(beta) * BW'(pos_s2[HW-1:0]);
			phi_s3  <= BW'(beta) * BW'(pos_s2[sesv_pkg::DOT_W-1:HW]);
			side_s3 <= side_s2;
			num_s4  <= (sesv_pkg::NUM1_W'(phi_s3) << HW) + sesv_pkg::NUM1_W'(plo_s3);
			side_s4 <= side_s3;
		end
	end

	assign out_vld  = vld_s4;
	assign num      = num_s4;
	assign out_side = side_s4;

endmodule

>>> rtl/sesv_div.sv
// ----------------------------------------------------------------------------
// sesv_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient does not fit in QW bits.
// ----------------------------------------------------------------------------
module sesv_div #(
	parameter int NW = 95,
	parameter int DW = 31,
	parameter int QW = 79,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [SW-1:0] out_side
);

	logic          vld_s  [0:QW];
	logic [DW-1:0] rem_s  [0:QW];
	logic [QW-1:0] quo_s  [0:QW];
	logic [QW-1:0] lo_s   [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic          ovf_s  [0:QW];
	logic [SW-1:0] side_s [0:QW];
	logic [DW-1:0] head;

	assign head = DW'(num[NW-1:QW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= QW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= head;
			quo_s[0]  <= '0;
			lo_s[0]   <= num[QW-1:0];
			den_s[0]  <= den;
			ovf_s[0]  <= head >= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_step
		localparam int I = QW - j;
		logic [DW:0] sh;
		logic [DW:0] diff;
		logic        ge;

		assign sh   = {rem_s[j-1], lo_s[j-1][I]};
		assign diff = sh - {1'b0, den_s[j-1]};
		assign ge   = sh >= {1'b0, den_s[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
				quo_s[j]  <= quo_s[j-1] | (QW'(ge) << I);
				lo_s[j]   <= lo_s[j-1];
				den_s[j]  <= den_s[j-1];
				ovf_s[j]  <= ovf_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quo      = quo_s[QW];
	assign ovf      = ovf_s[QW];
	assign out_side = side_s[QW];

endmodule

>>> rtl/sesv_root.sv
// ----------------------------------------------------------------------------
// sesv_root
// Pipelined integer square root, floor, one result bit per stage.
// ----------------------------------------------------------------------------
module sesv_root #(
	parameter int IW = 48,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [IW-1:0]   x,
	input  logic [SW-1:0]   in_side,
	output logic            out_vld,
	output logic [IW/2-1:0] root,
	output logic [SW-1:0]   out_side
);

	localparam int RW = IW / 2;
	localparam int TW = IW + 1;

	logic          vld_s  [0:RW];
	logic [IW-1:0] rem_s  [0:RW];
	logic [RW-1:0] root_s [0:RW];
	logic [SW-1:0] side_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= RW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= RW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= x;
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 1; j <= RW; j++) begin : g_step
		localparam int B = RW - j;
		logic [TW-1:0] trial;
		logic [TW-1:0] diff;
		logic          ge;

		assign trial = (TW'(root_s[j-1]) << (B + 1)) | (TW'(1) << (2 * B));
		assign diff  = TW'(rem_s[j-1]) - trial;
		assign ge    = TW'(rem_s[j-1]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[IW-1:0] : rem_s[j-1];
				root_s[j] <= root_s[j-1] | (RW'(ge) << B);
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_vld  = vld_s[RW];
	assign root     = root_s[RW];
	assign out_side = side_s[RW];

endmodule

>>> rtl/sesv_cbrt.sv
// ----------------------------------------------------------------------------
// sesv_cbrt
// Pipelined integer cube root, floor, one result bit per stage. Tracks
// 3r and 3r^2 so each stage needs only shifts and adds.
// ----------------------------------------------------------------------------
module sesv_cbrt #(
	parameter int SW = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [sesv_pkg::CBRT_IW-1:0]     x,
	input  logic [SW-1:0]                    in_side,
	output logic                             out_vld,
	output logic [sesv_pkg::CBRT_RW-1:0]     root,
	output logic [SW-1:0]                    out_side
);

	localparam int IW  = sesv_pkg::CBRT_IW;
	localparam int RW  = sesv_pkg::CBRT_RW;
	localparam int DLW = sesv_pkg::CBRT_DW;
	localparam int R3W = sesv_pkg::CBRT_R3;
	localparam int S3W = sesv_pkg::CBRT_S3;

	logic           vld_s  [0:RW];
	logic [IW-1:0]  rem_s  [0:RW];
	logic [RW-1:0]  root_s [0:RW];
	logic [R3W-1:0] r3_s   [0:RW];
	logic [S3W-1:0] s3_s   [0:RW];
	logic [SW-1:0]  side_s [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= RW; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int k = 1; k <= RW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= x;
			root_s[0] <= '0;
			r3_s[0]   <= '0;
			s3_s[0]   <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar j = 1; j <= RW; j++) begin : g_step
		localparam int B = RW - j;
		logic [DLW-1:0] delta;
		logic [DLW-1:0] diff;
		logic           ge;

		// (r + 2^b)^3 - r^3 = 3r^2*2^b + 3r*2^2b + 2^3b
		assign delta = (DLW'(s3_s[j-1]) << B) + (DLW'(r3_s[j-1]) << (2 * B))
			+ (DLW'(1) << (3 * B));
		assign diff  = DLW'(rem_s[j-1]) - delta;
		assign ge    = DLW'(rem_s[j-1]) >= delta;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= ge ? diff[IW-1:0] : rem_s[j-1];
				root_s[j] <= root_s[j-1] | (RW'(ge) << B);
				r3_s[j]   <= ge ? r3_s[j-1] + (R3W'(3) << B) : r3_s[j-1];
				s3_s[j]   <= ge ? s3_s[j-1] + (S3W'(r3_s[j-1]) << (B + 1))
					+ (S3W'(3) << (2 * B)) : s3_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_vld  = vld_s[RW];
	assign root     = root_s[RW];
	assign out_side = side_s[RW];

endmodule

>>> rtl/sesv_visc.sv
// ----------------------------------------------------------------------------
// sesv_visc
// Viscosity product cmu*rho*root*length >> 48 with saturation, split into
// partial products over four stages.
// ----------------------------------------------------------------------------
module sesv_visc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [sesv_pkg::UQ_W-1:0]     cmu,
	input  logic [sesv_pkg::UQ_W-1:0]     rho,
	input  logic [sesv_pkg::ROOT_W-1:0]   root,
	input  logic [sesv_pkg::LEN_W-1:0]    length_in,
	output logic                          out_vld,
	output logic [sesv_pkg::UQ_W-1:0]     visc,
	output logic [sesv_pkg::LEN_W-1:0]    length_out
);

	localparam int AW  = 2 * sesv_pkg::UQ_W;
	localparam int BW  = sesv_pkg::ROOT_W + sesv_pkg::LEN_W;
	localparam int AH  = AW / 2;
	localparam int BH  = BW / 2;
	localparam int PPW = AH + BH;
	localparam int PW  = AW + BW;
	localparam int SH  = 48;

	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [AW-1:0]               a_s1;
	logic [BW-1:0]               b_s1;
	logic [PPW-1:0]              p00_s2, p01_s2, p10_s2, p11_s2;
	logic [PW-1:0]               prod_s3;
	logic [sesv_pkg::UQ_W-1:0]   visc_s4;
	logic [sesv_pkg::LEN_W-1:0]  len_s1, len_s2, len_s3, len_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= AW'(cmu) * AW'(rho);
			b_s1    <= BW'(root) * BW'(length_in);
			len_s1  <= length_in;
			p00_s2  <= PPW'(a_s1[AH-1:0])  * PPW'(b_s1[BH-1:0]);
			p01_s2  <= PPW'(a_s1[AH-1:0])  * PPW'(b_s1[BW-1:BH]);
			p10_s2  <= PPW'(a_s1[AW-1:AH]) * PPW'(b_s1[BH-1:0]);
			p11_s2  <= PPW'(a_s1[AW-1:AH]) * PPW'(b_s1[BW-1:BH]);
			len_s2  <= len_s1;
			prod_s3 <= PW'(p00_s2) + (PW'(p01_s2) << BH) + (PW'(p10_s2) << AH)
				+ (PW'(p11_s2) << (AH + BH));
			len_s3  <= len_s2;
			visc_s4 <= (prod_s3[PW-1:SH+sesv_pkg::UQ_W] != '0) ? '1
				: prod_s3[SH+sesv_pkg::UQ_W-1:SH];
			len_s4  <= len_s3;
		end
	end

	assign out_vld    = vld_s4;
	assign visc       = visc_s4;
	assign length_out = len_s4;

endmodule

>>> rtl/stratified_sgs_eddy_viscosity_core.sv
// ----------------------------------------------------------------------------
// stratified_sgs_eddy_viscosity_core
// Stratification-limited subgrid length scale and eddy viscosity per node.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  s_axis    | in        | tvalid/tready        | tdata: node item, 240 bits
//  m_axis    | out       | tvalid/tready        | tdata: result item, 64 bits
//  cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One item per cycle sustained unless the output stage is full; results
//  pass the divider, root and cube-root pipelines to the output register.
//  Async active-low reset clears valid bits and loads register defaults.
//  A two-entry output stage (register plus skid) frees the pipeline while a
//  result waits; the pipeline holds only when both entries are full.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module stratified_sgs_eddy_viscosity_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cell_volume, kinetic_energy, fluid_density, grad_x, grad_y, grad_z,
	// heat_capacity, zero pad
	input  logic [sesv_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// length_scale, eddy_viscosity, zero pad
	output logic [sesv_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [2:0]                           cfg_index,
	input  logic [31:0]                          cfg_data
);

	sesv_pkg::cfg_regs_t  cfg_q;
	sesv_pkg::in_item_t   in_item;
	sesv_pkg::out_item_t  out_q, skid_q, fin_item;
	logic                 out_vld_q, skid_vld_q;
	logic                 en, two_d;

	sesv_pkg::dot_side_t  dot_si, dot_so;
	sesv_pkg::div_side_t  d1_si, d1_so, d2_si, d2_so;
	sesv_pkg::lim_side_t  lm_si, lm_so;
	sesv_pkg::f2_side_t   f2_si, f2_so;
	sesv_pkg::f3_side_t   f3_si, f3_so;
	sesv_pkg::rt_side_t   rt_si, rt_so;

	logic                                dot_vld, d1_vld, d2_vld, lm_vld;
	logic                                f2_vld, f3_vld, rt_vld, fin_vld;
	logic [sesv_pkg::NUM1_W-1:0]         num1;
	logic [sesv_pkg::STRAT_W-1:0]        q1, strat;
	logic                                ovf1, ovf2;
	logic [sesv_pkg::QLIM_W-1:0]         q2;
	logic [sesv_pkg::LEN_W-1:0]          limit, filter, length, fin_len;
	logic [sesv_pkg::ROOT_W-1:0]         vroot, kroot;
	logic [sesv_pkg::CBRT_RW-1:0]        croot;
	logic [34:0]                         k9;
	logic [sesv_pkg::UQ_W-1:0]           cp_nz, fin_visc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expansion_coeff <= '0;
			cfg_q.gravity_x       <= '0;
			cfg_q.gravity_y       <= '0;
			cfg_q.gravity_z       <= sesv_pkg::GRAVITY_Z_RST;
			cfg_q.viscosity_coeff <= sesv_pkg::VISC_RST;
			cfg_q.space_dims      <= 2'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				sesv_pkg::CFG_EXPANSION: cfg_q.expansion_coeff <= cfg_data[30:0];
				sesv_pkg::CFG_GRAVITY_X: cfg_q.gravity_x       <= cfg_data;
				sesv_pkg::CFG_GRAVITY_Y: cfg_q.gravity_y       <= cfg_data;
				sesv_pkg::CFG_GRAVITY_Z: cfg_q.gravity_z       <= cfg_data;
				sesv_pkg::CFG_VISCOSITY: cfg_q.viscosity_coeff <= cfg_data[30:0];
				sesv_pkg::CFG_DIMS:      cfg_q.space_dims      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign two_d         = cfg_q.space_dims == sesv_pkg::DIMS_2D;
	assign en            = !skid_vld_q;
	assign s_axis_tready = en;
	assign in_item       = s_axis_tdata;

	assign dot_si.vol = in_item.cell_volume;
	assign dot_si.ke  = in_item.kinetic_energy;
	assign dot_si.rho = in_item.fluid_density;
	assign dot_si.cp  = in_item.heat_capacity;

	sesv_dot #(.SW($bits(sesv_pkg::dot_side_t))) u_dot (
		.clk, .arst_n, .en,
		.in_vld    (s_axis_tvalid && en),
		.grad_x    (in_item.grad_x),
		.grad_y    (in_item.grad_y),
		.grad_z    (in_item.grad_z),
		.gravity_x (cfg_q.gravity_x),
		.gravity_y (cfg_q.gravity_y),
		.gravity_z (cfg_q.gravity_z),
		.two_d     (two_d),
		.beta      (cfg_q.expansion_coeff),
		.in_side   (dot_si),
		.out_vld   (dot_vld),
		.num       (num1),
		.out_side  (dot_so)
	);

	assign cp_nz     = (dot_so.cp == '0) ? sesv_pkg::UQ_W'(1) : dot_so.cp;
	assign d1_si.vol = dot_so.vol;
	assign d1_si.ke  = dot_so.ke;
	assign d1_si.rho = dot_so.rho;

	sesv_div #(
		.NW(sesv_pkg::NUM1_W), .DW(sesv_pkg::UQ_W), .QW(sesv_pkg::STRAT_W),
		.SW($bits(sesv_pkg::div_side_t))
	) u_div_strat (
		.clk, .arst_n, .en,
		.in_vld   (dot_vld),
		.num      (num1),
		.den      (cp_nz),
		.in_side  (d1_si),
		.out_vld  (d1_vld),
		.quo      (q1),
		.ovf      (ovf1),
		.out_side (d1_so)
	);

	// stratification above the quotient range only needs to stay large
	assign strat = ovf1 ? '1 : q1;
	assign k9    = 35'({d1_so.ke, 3'b000}) + 35'(d1_so.ke);
	assign d2_si = d1_so;

	sesv_div #(
		.NW(sesv_pkg::STRAT_W), .DW(sesv_pkg::STRAT_W), .QW(sesv_pkg::QLIM_W),
		.SW($bits(sesv_pkg::div_side_t))
	) u_div_lim (
		.clk, .arst_n, .en,
		.in_vld   (d1_vld),
		.num      ({k9, 44'd0}),
		.den      (strat),
		.in_side  (d2_si),
		.out_vld  (d2_vld),
		.quo      (q2),
		.ovf      (ovf2),
		.out_side (d2_so)
	);

	// overflow covers zero stratification and any limit beyond the filter range
	assign lm_si.vol = d2_so.vol;
	assign lm_si.ke  = d2_so.ke;
	assign lm_si.rho = d2_so.rho;
	assign lm_si.ovf = ovf2;

	sesv_root #(.IW(sesv_pkg::QLIM_W), .SW($bits(sesv_pkg::lim_side_t))) u_root_lim (
		.clk, .arst_n, .en,
		.in_vld   (d2_vld),
		.x        (q2),
		.in_side  (lm_si),
		.out_vld  (lm_vld),
		.root     (limit),
		.out_side (lm_so)
	);

	assign f2_si.vol   = lm_so.vol;
	assign f2_si.ke    = lm_so.ke;
	assign f2_si.rho   = lm_so.rho;
	assign f2_si.ovf   = lm_so.ovf;
	assign f2_si.limit = limit;

	sesv_root #(.IW(sesv_pkg::VOL_W), .SW($bits(sesv_pkg::f2_side_t))) u_root_vol (
		.clk, .arst_n, .en,
		.in_vld   (lm_vld),
		.x        (lm_so.vol),
		.in_side  (f2_si),
		.out_vld  (f2_vld),
		.root     (vroot),
		.out_side (f2_so)
	);

	assign f3_si.ke    = f2_so.ke;
	assign f3_si.rho   = f2_so.rho;
	assign f3_si.ovf   = f2_so.ovf;
	assign f3_si.limit = f2_so.limit;
	assign f3_si.f2d   = vroot[sesv_pkg::ROOT_W-1:4];

	sesv_cbrt #(.SW($bits(sesv_pkg::f3_side_t))) u_cbrt (
		.clk, .arst_n, .en,
		.in_vld   (f2_vld),
		.x        ({f2_so.vol, 8'd0}),
		.in_side  (f3_si),
		.out_vld  (f3_vld),
		.root     (croot),
		.out_side (f3_so)
	);

	assign filter    = two_d ? f3_so.f2d : sesv_pkg::LEN_W'(croot);
	assign length    = (!f3_so.ovf && f3_so.limit < filter) ? f3_so.limit : filter;
	assign rt_si.rho    = f3_so.rho;
	assign rt_si.length = length;

	sesv_root #(.IW(sesv_pkg::VOL_W), .SW($bits(sesv_pkg::rt_side_t))) u_root_ke (
		.clk, .arst_n, .en,
		.in_vld   (f3_vld),
		.x        ({1'b0, f3_so.ke, 16'd0}),
		.in_side  (rt_si),
		.out_vld  (rt_vld),
		.root     (kroot),
		.out_side (rt_so)
	);

	sesv_visc u_visc (
		.clk, .arst_n, .en,
		.in_vld     (rt_vld),
		.cmu        (cfg_q.viscosity_coeff),
		.rho        (rt_so.rho),
		.root       (kroot),
		.length_in  (rt_so.length),
		.out_vld    (fin_vld),
		.visc       (fin_visc),
		.length_out (fin_len)
	);

	assign fin_item.pad            = '0;
	assign fin_item.eddy_viscosity = fin_visc;
	assign fin_item.length_scale   = sesv_pkg::UQ_W'(fin_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!skid_vld_q) begin
			if (!out_vld_q || m_axis_tready) begin
				out_vld_q <= fin_vld;
			end else if (fin_vld) begin
				skid_vld_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			if (!out_vld_q || m_axis_tready) begin
				out_q <= fin_item;
			end else begin
				skid_q <= fin_item;
			end
		end else if (m_axis_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held without output entry");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
		else $error("skid filled while output was free");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!skid_vld_q && out_vld_q && !m_axis_tready && fin_vld) |=> skid_vld_q)
		else $error("finished item dropped at output stage");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[30:20] == 11'd0))
		else $error("length scale above filter range");
`endif

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stratified SGS eddy viscosity core: node items
// stream in with random bursts and gaps while the output side stalls on its
// own pattern. A bit-exact predictor computes length scale and viscosity for
// every accepted node, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [sesv_pkg::TDATA_IN_W-1:0]  s_axis_tdata;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [sesv_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [2:0]                       cfg_index;
	logic [31:0]                      cfg_data;

	stratified_sgs_eddy_viscosity_core DUT (.*);

	// predictor copy of the registers
	logic [30:0]        beta;
	logic signed [31:0] grav_x, grav_y, grav_z;
	logic [30:0]        cmu;
	logic [1:0]         dims;

	sesv_pkg::out_item_t expected_results[$];
	int        err_count = 0;
	int        hold_cycles = 0;
	bit        no_gaps = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, y;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			y = r | (64'd1 << b);
			if (y * y <= x) r = y;
		end
		return r;
	endfunction

	function automatic logic [63:0] icbrt(logic [63:0] x);
		logic [63:0] r, y;
		r = 0;
		for (int b = 18; b >= 0; b--) begin
			y = r | (64'd1 << b);
			if (y * y * y <= x) r = y;
		end
		return r;
	endfunction

	function automatic sesv_pkg::out_item_t predict_node(sesv_pkg::in_item_t n);
		logic [63:0]        cp, filter, len, lim, root, visc;
		logic signed [65:0] dot, a, b;
		logic [127:0]       strat, num, q, prod;
		bit                 two_d;
		sesv_pkg::out_item_t r;
		two_d = (dims == sesv_pkg::DIMS_2D);
		cp = (n.heat_capacity == 0) ? 64'd1 : 64'(n.heat_capacity);
		filter = two_d ? (isqrt(64'(n.cell_volume)) >> 4) : icbrt(64'(n.cell_volume) << 8);
		a = grav_x; b = $signed(n.grad_x); dot = a * b;
		a = grav_y; b = $signed(n.grad_y); dot += a * b;
		if (!two_d) begin
			a = grav_z; b = $signed(n.grad_z); dot += a * b;
		end
		len = filter;
		if (beta != 0 && dot > 0) begin
			strat = (128'(beta) * 128'(dot[63:0])) / 128'(cp);
			if (strat != 0) begin
				num = (128'(n.kinetic_energy) * 128'd9) << 44;
				q = num / strat;
				lim = (q < (128'd1 << 62)) ? isqrt(q[63:0]) : (64'd1 << 31);
				if (lim < filter) len = lim;
			end
		end
		root = isqrt(64'(n.kinetic_energy) << 16);
		prod = (128'(cmu) * 128'(n.fluid_density)) * (128'(root) * 128'(len));
		prod = prod >> 48;
		visc = (prod > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : prod[63:0];
		r = '0;
		r.length_scale = len[30:0];
		r.eddy_viscosity = visc[30:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		sesv_pkg::out_item_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_results.size() == 0) begin
				$error("unexpected result item %h", m_axis_tdata);
				err_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.length_scale !== exp_r.length_scale) begin
					$error("length_scale expected %0d actual %0d",
						exp_r.length_scale, got.length_scale);
					err_count++;
				end
				if (got.eddy_viscosity !== exp_r.eddy_viscosity) begin
					$error("eddy_viscosity expected %0d actual %0d",
						exp_r.eddy_viscosity, got.eddy_viscosity);
					err_count++;
				end
			end
		end
	end

	// output stall pattern, with long hold-off on request
	initial begin
		int stall_pct;
		int phase_left;
		m_axis_tready = 0;
		stall_pct = 0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			phase_left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	int burst_left = 0;

	task automatic send_node(sesv_pkg::in_item_t n);
		n.pad = '0;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= n;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(predict_node(n));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if (!no_gaps) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic write_reg(sesv_pkg::cfg_index_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sesv_pkg::CFG_EXPANSION: beta = value[30:0];
			sesv_pkg::CFG_GRAVITY_X: grav_x = value;
			sesv_pkg::CFG_GRAVITY_Y: grav_y = value;
			sesv_pkg::CFG_GRAVITY_Z: grav_z = value;
			sesv_pkg::CFG_VISCOSITY: cmu = value[30:0];
			sesv_pkg::CFG_DIMS:      dims = value[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (260) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] b, logic [31:0] gx, logic [31:0] gy,
			logic [31:0] gz, logic [31:0] c, logic [31:0] d);
		write_reg(sesv_pkg::CFG_EXPANSION, b);
		write_reg(sesv_pkg::CFG_GRAVITY_X, gx);
		write_reg(sesv_pkg::CFG_GRAVITY_Y, gy);
		write_reg(sesv_pkg::CFG_GRAVITY_Z, gz);
		write_reg(sesv_pkg::CFG_VISCOSITY, c);
		write_reg(sesv_pkg::CFG_DIMS, d);
	endtask

	function automatic logic [63:0] rand_bits(int width);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v = v & ((64'd1 << width) - 1);
		return v >> $urandom_range(0, width);
	endfunction

	function automatic sesv_pkg::in_item_t make_node(int unsigned flavor);
		sesv_pkg::in_item_t n;
		n = '0;
		n.cell_volume = 48'(rand_bits(48));
		n.kinetic_energy = 31'(rand_bits(31));
		n.fluid_density = 31'(rand_bits(31));
		n.heat_capacity = 31'(rand_bits(31));
		if (n.heat_capacity == 0) n.heat_capacity = 31'd1;
		n.grad_x = 32'(rand_bits(32));
		n.grad_y = 32'(rand_bits(32));
		n.grad_z = 32'(rand_bits(32));
		// mostly gradients aligned with gravity so stratification is positive
		if (flavor < 70) begin
			if ((grav_x < 0) != n.grad_x[31]) n.grad_x = -n.grad_x;
			if ((grav_y < 0) != n.grad_y[31]) n.grad_y = -n.grad_y;
			if ((grav_z < 0) != n.grad_z[31]) n.grad_z = -n.grad_z;
		end
		return n;
	endfunction

	task automatic send_random(int count);
		repeat (count) send_node(make_node($urandom_range(0, 99)));
	endtask

	task automatic test_defaults;
		sesv_pkg::in_item_t n;
		n = '0;
		n.cell_volume = 48'd1 << 40;
		n.kinetic_energy = 31'd1 << 16;
		n.fluid_density = 31'd1 << 16;
		n.heat_capacity = 31'd1 << 16;
		n.grad_z = -32'sd65536;
		send_node(n);
		send_random(10);
		drain();
	endtask

	task automatic test_directed;
		sesv_pkg::in_item_t n;
		set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'd3);
		n = '0;
		send_node(n);
		n.cell_volume = '1;
		n.kinetic_energy = '1;
		n.fluid_density = '1;
		n.heat_capacity = '1;
		n.grad_x = 32'h7FFF_FFFF;
		n.grad_y = 32'h8000_0000;
		n.grad_z = 32'h8000_0000;
		send_node(n);
		n.heat_capacity = 31'd0;
		send_node(n);
		n.heat_capacity = 31'd1;
		send_node(n);
		n.kinetic_energy = 31'd1;
		send_node(n);
		n.grad_x = 32'h8000_0000;
		n.grad_y = 32'h7FFF_FFFF;
		n.grad_z = 32'h7FFF_FFFF;
		send_node(n);
		n.grad_x = 32'sd0; n.grad_y = 32'sd0; n.grad_z = 32'sd0;
		send_node(n);
		n.cell_volume = 48'd1;
		n.grad_x = 32'sd1;
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_DIMS, 32'd2);
		n.cell_volume = '1;
		n.grad_z = 32'h8000_0000;
		send_node(n);
		n.grad_x = 32'h7FFF_FFFF;
		n.grad_y = 32'h8000_0000;
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_DIMS, 32'd0);
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_DIMS, 32'd1);
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_EXPANSION, 32'd0);
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_EXPANSION, 32'hFFFF_FFFF);
		write_reg(sesv_pkg::CFG_VISCOSITY, 32'hFFFF_FFFF);
		send_node(n);
		drain();
		write_reg(sesv_pkg::CFG_VISCOSITY, 32'd0);
		send_node(n);
		drain();
	endtask

	task automatic test_random_configs;
		for (int k = 0; k < 6; k++) begin
			set_config(32'(rand_bits(32)), 32'(rand_bits(32)), 32'(rand_bits(32)),
				32'(rand_bits(32)), 32'(rand_bits(32)), 32'($urandom_range(0, 3)));
			if (k == 1) write_reg(sesv_pkg::CFG_DIMS, 32'd2);
			send_random(250);
			drain();
		end
	endtask

	task automatic test_backpressure;
		set_config(32'h0001_0000, 32'd0, 32'd0, -32'sd642908, 32'd5610, 32'd3);
		no_gaps = 1;
		hold_cycles = 800;
		send_random(300);
		no_gaps = 0;
		drain();
	endtask

	initial begin
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = sesv_pkg::CFG_EXPANSION;
		cfg_data = '0;
		beta = 0;
		grav_x = 0;
		grav_y = 0;
		grav_z = sesv_pkg::GRAVITY_Z_RST;
		cmu = sesv_pkg::VISC_RST;
		dims = 2'd3;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_defaults();
		test_directed();
		test_random_configs();
		test_backpressure();
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
